### rtl/wct_pkg.sv
// Shared types and constants for the wave channel trigger and timer block.
package wct_pkg;

    localparam int LENGTH_LIMIT = 256;
    localparam logic [8:0] LENGTH_LIMIT_W = 9'(LENGTH_LIMIT);

    // register offsets from the channel's base address
    localparam logic [2:0] REG_DAC  = 3'd0;
    localparam logic [2:0] REG_LEN  = 3'd1;
    localparam logic [2:0] REG_FLO  = 3'd3;
    localparam logic [2:0] REG_CTRL = 3'd4;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [11:0] PERIOD_BASE = 12'd2048;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_DAC,
        CMD_LEN,
        CMD_FLO,
        CMD_CTRL,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;      // write byte or elapsed cycles
        logic       step_odd;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOP,
        BK_DONE
    } bk_state_t;

    // (2048 - f) * 2 for the 11-bit frequency f
    function automatic logic [12:0] period_of(input logic [2:0] hi, input logic [7:0] lo);
        logic [11:0] diff;
        diff = PERIOD_BASE - {1'b0, hi, lo};
        return {diff, 1'b0};
    endfunction

endpackage

### rtl/wct_front.sv
// Front end: decodes each accepted request into a command for the queue.
module wct_front (
    input  logic             s_req_type,
    input  logic [2:0]       s_reg_select,
    input  logic [7:0]       s_write_data,
    input  logic [7:0]       s_elapsed_cycles,
    input  logic             s_sequencer_step_odd,
    output wct_pkg::cmd_t    cmd
);

    always_comb begin
        cmd.step_odd = s_sequencer_step_odd;
        if (s_req_type == wct_pkg::REQ_TICK) begin
            cmd.kind = wct_pkg::CMD_TICK;
            cmd.data = s_elapsed_cycles;
        end else begin
            cmd.data = s_write_data;
            unique case (s_reg_select)
                wct_pkg::REG_DAC:  cmd.kind = wct_pkg::CMD_DAC;
                wct_pkg::REG_LEN:  cmd.kind = wct_pkg::CMD_LEN;
                wct_pkg::REG_FLO:  cmd.kind = wct_pkg::CMD_FLO;
                wct_pkg::REG_CTRL: cmd.kind = wct_pkg::CMD_CTRL;
                default:           cmd.kind = wct_pkg::CMD_NOP;
            endcase
        end
    end

endmodule

### rtl/wct_fifo.sv
// Short command queue between the front end and the execution back end.
module wct_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  wct_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output wct_pkg::cmd_t head_cmd
);

    wct_pkg::cmd_t                     mem_reg [wct_pkg::FIFO_DEPTH];
    logic [wct_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [wct_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [wct_pkg::FIFO_CNT_W-1:0]    count_reg, count_next;

    localparam logic [wct_pkg::FIFO_CNT_W-1:0] DEPTH_W =
        wct_pkg::FIFO_CNT_W'(wct_pkg::FIFO_DEPTH);
    localparam logic [wct_pkg::FIFO_PTR_W-1:0] LAST_PTR =
        wct_pkg::FIFO_PTR_W'(wct_pkg::FIFO_DEPTH - 1);

    assign full      = (count_reg == DEPTH_W);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/wct_back.sv
// Back end: applies register writes and runs the period timer for ticks.
module wct_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    input  wct_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_channel_active,
    output logic [4:0]    m_wave_position,
    output logic [8:0]    m_length_count
);

    wct_pkg::bk_state_t state_reg, state_next;

    logic        dac_reg, dac_next;
    logic [7:0]  flo_reg, flo_next;
    logic [2:0]  fhi_reg, fhi_next;
    logic        len_en_reg, len_en_next;
    logic [8:0]  len_reg, len_next;
    logic        run_reg, run_next;
    logic [12:0] timer_reg, timer_next;
    logic [4:0]  pos_reg, pos_next;
    logic [13:0] t_reg, t_next;       // two's complement working timer
    logic        valid_reg, valid_next;

    logic        slot_free;
    logic        t_expired;
    logic [12:0] period;

    assign slot_free = !valid_reg || m_ready;
    assign t_expired = t_reg[13] || (t_reg == '0);
    assign period    = wct_pkg::period_of(fhi_reg, flo_reg);

    assign m_valid          = valid_reg;
    assign m_channel_active = run_reg;
    assign m_wave_position  = pos_reg;
    assign m_length_count   = len_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wct_pkg::BK_IDLE: begin
                if (cmd_valid && slot_free && cmd.kind == wct_pkg::CMD_TICK) begin
                    state_next = wct_pkg::BK_LOOP;
                end
            end
            wct_pkg::BK_LOOP: begin
                if (!t_expired) begin
                    state_next = wct_pkg::BK_DONE;
                end
            end
            wct_pkg::BK_DONE: state_next = wct_pkg::BK_IDLE;
            default:          state_next = wct_pkg::BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [12:0] new_period;
        new_period  = wct_pkg::period_of(cmd.data[2:0], flo_reg);
        cmd_pop     = 1'b0;
        dac_next    = dac_reg;
        flo_next    = flo_reg;
        fhi_next    = fhi_reg;
        len_en_next = len_en_reg;
        len_next    = len_reg;
        run_next    = run_reg;
        timer_next  = timer_reg;
        pos_next    = pos_reg;
        t_next      = t_reg;
        valid_next  = valid_reg && !m_ready;
        unique case (state_reg)
            wct_pkg::BK_IDLE: begin
                if (cmd_valid && slot_free) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        wct_pkg::CMD_TICK: begin
                            t_next = {1'b0, timer_reg} - {6'b0, cmd.data};
                        end
                        wct_pkg::CMD_DAC: begin
                            valid_next = 1'b1;
                            dac_next   = cmd.data[7];
                            if (!cmd.data[7]) begin
                                run_next = 1'b0;
                            end
                        end
                        wct_pkg::CMD_LEN: begin
                            valid_next = 1'b1;
                            len_next   = {1'b0, cmd.data};
                        end
                        wct_pkg::CMD_FLO: begin
                            valid_next = 1'b1;
                            flo_next   = cmd.data;
                        end
                        wct_pkg::CMD_CTRL: begin
                            valid_next  = 1'b1;
                            len_en_next = cmd.data[6];
                            fhi_next    = cmd.data[2:0];
                            // extra length clock on a rising enable in an even step
                            if (!len_en_reg && cmd.data[6] && !cmd.step_odd
                                && len_reg < wct_pkg::LENGTH_LIMIT_W) begin
                                len_next = len_reg + 9'd1;
                                if (len_next >= wct_pkg::LENGTH_LIMIT_W) begin
                                    run_next = 1'b0;
                                end
                            end
                            if (cmd.data[7]) begin
                                if (len_next >= wct_pkg::LENGTH_LIMIT_W) begin
                                    len_next = (cmd.data[6] && !cmd.step_odd) ? 9'd1 : 9'd0;
                                end
                                if (dac_reg) begin
                                    run_next = 1'b1;
                                end
                                timer_next = new_period;
                                pos_next   = '0;
                            end
                        end
                        default: begin
                            valid_next = 1'b1;
                        end
                    endcase
                end
            end
            wct_pkg::BK_LOOP: begin
                // add one period per expired step, advance the wave position
                if (t_expired) begin
                    t_next   = t_reg + {1'b0, period};
                    pos_next = pos_reg + 5'd1;
                end else begin
                    timer_next = t_reg[12:0];
                end
            end
            wct_pkg::BK_DONE: begin
                valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= wct_pkg::BK_IDLE;
            valid_reg  <= 1'b0;
            dac_reg    <= 1'b0;
            flo_reg    <= '0;
            fhi_reg    <= '0;
            len_en_reg <= 1'b0;
            len_reg    <= '0;
            run_reg    <= 1'b0;
            timer_reg  <= '0;
            pos_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            dac_reg    <= dac_next;
            flo_reg    <= flo_next;
            fhi_reg    <= fhi_next;
            len_en_reg <= len_en_next;
            len_reg    <= len_next;
            run_reg    <= run_next;
            timer_reg  <= timer_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg <= t_next;
    end

endmodule

### rtl/wave_channel_trigger_and_timer.sv
// Top level of the wave channel trigger, length counter and period timer.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    req_type, reg_select, write_data,
//                                          elapsed_cycles, sequencer_step_odd
//   m_       out        m_valid/m_ready    channel_active, wave_position, length_count
//
// The back end applies a register write from its idle state. A tick passes through its
// period-add loop, once per elapsed period n (0 to 128), and then through its done state.
// Requests wait in a two-entry queue; s_ready drops once both entries are taken, while the
// back end works on a tick or a result waits on m_ready.
// Synchronous active-low reset clears all channel state.
module wave_channel_trigger_and_timer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [2:0] s_reg_select,
    input  logic [7:0] s_write_data,
    input  logic [7:0] s_elapsed_cycles,
    input  logic       s_sequencer_step_odd,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_channel_active,
    output logic [4:0] m_wave_position,
    output logic [8:0] m_length_count
);

    wct_pkg::cmd_t front_cmd;
    wct_pkg::cmd_t head_cmd;
    logic          fifo_full;
    logic          fifo_not_empty;
    logic          cmd_pop;

    assign s_ready = !fifo_full;

    wct_front u_front (
        .s_req_type           (s_req_type),
        .s_reg_select         (s_reg_select),
        .s_write_data         (s_write_data),
        .s_elapsed_cycles     (s_elapsed_cycles),
        .s_sequencer_step_odd (s_sequencer_step_odd),
        .cmd                  (front_cmd)
    );

    wct_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_cmd  (front_cmd),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .not_empty (fifo_not_empty),
        .head_cmd  (head_cmd)
    );

    wct_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (fifo_not_empty),
        .cmd              (head_cmd),
        .cmd_pop          (cmd_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_channel_active (m_channel_active),
        .m_wave_position  (m_wave_position),
        .m_length_count   (m_length_count)
    );

endmodule

### bench/wct_checker.sv
// Result checker for the wave channel block: predicts every result and compares it.
module wct_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_req_type,
    input  logic [2:0] s_reg_select,
    input  logic [7:0] s_write_data,
    input  logic [7:0] s_elapsed_cycles,
    input  logic       s_sequencer_step_odd,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_channel_active,
    input  logic [4:0] m_wave_position,
    input  logic [8:0] m_length_count,
    output int         mismatches,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       active;
        logic [4:0] pos;
        logic [8:0] len;
    } chan_status_t;

    // shadow copy of the channel
    logic        dac_on;
    logic [7:0]  freq_lo;
    logic [2:0]  freq_hi;
    logic        len_en;
    logic [8:0]  len_cnt;
    logic        running;
    logic [12:0] timer;
    logic [4:0]  pos;

    chan_status_t status_q[$];
    int err_count = 0;
    int result_num = 0;

    assign mismatches = err_count;
    assign pending    = status_q.size();

    function automatic int unsigned wave_period();
        int unsigned f;
        f = {freq_hi, freq_lo};
        return (2048 - f) * 2;
    endfunction

    function automatic chan_status_t advance_channel(logic req, logic [2:0] sel,
                                                     logic [7:0] data, logic [7:0] cyc,
                                                     logic odd);
        logic was_en;
        int unsigned per;
        int unsigned deficit;
        int unsigned n;
        if (req == wct_pkg::REQ_WRITE) begin
            case (sel)
                wct_pkg::REG_DAC: begin
                    dac_on = data[7];
                    if (!dac_on) running = 1'b0;
                end
                wct_pkg::REG_LEN: len_cnt = {1'b0, data};
                wct_pkg::REG_FLO: freq_lo = data;
                wct_pkg::REG_CTRL: begin
                    was_en  = len_en;
                    len_en  = data[6];
                    freq_hi = data[2:0];
                    // extra length clock on a rising enable in an even step
                    if (!was_en && len_en && !odd && len_cnt < wct_pkg::LENGTH_LIMIT_W) begin
                        len_cnt = len_cnt + 9'd1;
                        if (len_cnt >= wct_pkg::LENGTH_LIMIT_W) running = 1'b0;
                    end
                    if (data[7]) begin
                        if (len_cnt >= wct_pkg::LENGTH_LIMIT_W)
                            len_cnt = (len_en && !odd) ? 9'd1 : 9'd0;
                        if (dac_on) running = 1'b1;
                        timer = 13'(wave_period());
                        pos   = 5'd0;
                    end
                end
                default: ;
            endcase
        end else begin
            per = wave_period();
            if (timer > cyc) begin
                timer = timer - 13'(cyc);
            end else begin
                deficit = cyc - timer;
                n       = deficit / per + 1;
                pos     = 5'(pos + n);
                timer   = 13'(n * per - deficit);
            end
        end
        return '{running, pos, len_cnt};
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            err_count++;
            if (err_count <= 10)
                $display("result %0d: %s expected %0d, got %0d", result_num, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        chan_status_t exp_s;
        if (!aresetn) begin
            dac_on  = 1'b0;
            freq_lo = '0;
            freq_hi = '0;
            len_en  = 1'b0;
            len_cnt = '0;
            running = 1'b0;
            timer   = '0;
            pos     = '0;
            status_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (status_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("result %0d arrived with no request pending", result_num);
                end else begin
                    exp_s = status_q.pop_front();
                    check_field("channel_active", exp_s.active, m_channel_active);
                    check_field("wave_position", exp_s.pos, m_wave_position);
                    check_field("length_count", exp_s.len, m_length_count);
                end
                result_num++;
            end
            if (s_valid && s_ready)
                status_q.push_back(advance_channel(s_req_type, s_reg_select, s_write_data,
                                                   s_elapsed_cycles, s_sequencer_step_odd));
        end
    end

endmodule

### bench/wave_channel_trigger_and_timer_tb.sv
// Top of the wave channel bench: clock, reset, request stimulus, receiver and verdict.
module wave_channel_trigger_and_timer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_VOL        = 3'd2;
    localparam logic [2:0] REG_NONE_FIRST = 3'd5;
    localparam logic [2:0] REG_NONE_LAST  = 3'd7;
    localparam int HOLD_CYCLES    = 64;
    localparam int STALL_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 200;
    localparam int PHASE_REQUESTS = 160;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_req_type = wct_pkg::REQ_WRITE;
    logic [2:0] s_reg_select = '0;
    logic [7:0] s_write_data = '0;
    logic [7:0] s_elapsed_cycles = '0;
    logic       s_sequencer_step_odd = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_channel_active;
    logic [4:0] m_wave_position;
    logic [8:0] m_length_count;

    int  mismatches;
    int  pending;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  quiet_cycles = 0;
    logic hold_off = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    wave_channel_trigger_and_timer i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_req_type           (s_req_type),
        .s_reg_select         (s_reg_select),
        .s_write_data         (s_write_data),
        .s_elapsed_cycles     (s_elapsed_cycles),
        .s_sequencer_step_odd (s_sequencer_step_odd),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_channel_active     (m_channel_active),
        .m_wave_position      (m_wave_position),
        .m_length_count       (m_length_count)
    );

    wct_checker i_checker (.*);

    // receiver: random stalls, or one long hold-off counted here
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_off <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(logic req, logic [2:0] sel, logic [7:0] data,
                                logic [7:0] cyc, logic odd);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_req_type           <= req;
        s_reg_select         <= sel;
        s_write_data         <= data;
        s_elapsed_cycles     <= cyc;
        s_sequencer_step_odd <= odd;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(logic [2:0] sel, logic [7:0] data, logic odd);
        send_request(wct_pkg::REQ_WRITE, sel, data, 8'($urandom), odd);
    endtask

    task automatic tick(logic [7:0] cyc);
        send_request(wct_pkg::REQ_TICK, 3'($urandom), 8'($urandom), cyc, 1'($urandom));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
    endtask

    // mostly whole notes (setup, trigger, ticks), the rest raw noise
    task automatic play_random(int count);
        int sent;
        logic [7:0] ctl;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 20) begin
                send_request(1'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                             1'($urandom));
                sent++;
            end else begin
                write_reg(wct_pkg::REG_DAC, {1'($urandom_range(9) != 0), 7'($urandom)},
                          1'($urandom));
                write_reg(wct_pkg::REG_LEN, ($urandom_range(1) != 0)
                                            ? 8'($urandom_range(240, 255))
                                            : 8'($urandom), 1'($urandom));
                write_reg(wct_pkg::REG_FLO, 8'($urandom), 1'($urandom));
                ctl = 8'($urandom);
                ctl[7] = 1'b1;
                if ($urandom_range(1) != 0) ctl[2:0] = 3'd7;
                write_reg(wct_pkg::REG_CTRL, ctl, 1'($urandom));
                sent += 4;
                repeat ($urandom_range(2, 8)) begin
                    tick(8'($urandom));
                    sent++;
                end
                if ($urandom_range(1) != 0) begin
                    // toggle length enable to hit the extra length clock
                    ctl[6] = 1'b0;
                    ctl[7] = 1'b0;
                    write_reg(wct_pkg::REG_CTRL, ctl, 1'($urandom));
                    ctl[6] = 1'b1;
                    ctl[7] = 1'($urandom);
                    write_reg(wct_pkg::REG_CTRL, ctl, 1'($urandom));
                    tick(8'($urandom));
                    sent += 3;
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset state, extremes of frequency and length, odd offsets
        tick(8'd0);
        tick(8'd255);
        write_reg(wct_pkg::REG_DAC, 8'h80, 1'b0);
        write_reg(wct_pkg::REG_LEN, 8'hFF, 1'b0);
        write_reg(wct_pkg::REG_FLO, 8'hFF, 1'b0);
        write_reg(wct_pkg::REG_CTRL, 8'h47, 1'b0);
        write_reg(wct_pkg::REG_CTRL, 8'hC7, 1'b0);
        tick(8'd255);
        tick(8'd1);
        write_reg(REG_VOL, 8'hFF, 1'b0);
        for (int r = REG_NONE_FIRST; r <= REG_NONE_LAST; r++)
            write_reg(3'(r), 8'hFF, 1'b1);
        write_reg(wct_pkg::REG_LEN, 8'hFF, 1'b0);
        write_reg(wct_pkg::REG_CTRL, 8'h00, 1'b0);
        write_reg(wct_pkg::REG_CTRL, 8'h40, 1'b0);
        write_reg(wct_pkg::REG_CTRL, 8'h00, 1'b0);
        write_reg(wct_pkg::REG_CTRL, 8'h40, 1'b0);
        write_reg(wct_pkg::REG_CTRL, 8'h80, 1'b1);
        write_reg(wct_pkg::REG_FLO, 8'h00, 1'b0);
        write_reg(wct_pkg::REG_CTRL, 8'h80, 1'b0);
        tick(8'd255);
        write_reg(wct_pkg::REG_DAC, 8'h00, 1'b0);
        write_reg(wct_pkg::REG_CTRL, 8'h80, 1'b0);
        drain_results();

        idle_pct = 0;  stall_pct = 0;  play_random(PHASE_REQUESTS); drain_results();
        idle_pct = 71; stall_pct = 0;  play_random(PHASE_REQUESTS); drain_results();
        idle_pct = 0;  stall_pct = 71; play_random(PHASE_REQUESTS); drain_results();
        idle_pct = 7;  stall_pct = 7;  play_random(PHASE_REQUESTS); drain_results();

        // hold the receiver off while requests keep coming, to back up the input
        idle_pct = 0;  stall_pct = 0;
        hold_off <= 1'b1;
        play_random(40);
        drain_results();
        play_random(PHASE_REQUESTS);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### wave_channel_trigger_and_timer.f
rtl/wct_pkg.sv
rtl/wct_front.sv
rtl/wct_fifo.sv
rtl/wct_back.sv
rtl/wave_channel_trigger_and_timer.sv
bench/wct_checker.sv
bench/wave_channel_trigger_and_timer_tb.sv
